// ===== hw/rtl/ctu_pkg.sv =====
// ----------------------------------------------------------------------------
// ctu_pkg
// Shared types, constants and saturation helpers for the cable tension unit.
// ----------------------------------------------------------------------------
package ctu_pkg;

   // Iterative divider: magnitude shifted up by 16 over the cable length or norm
   localparam int DIV_NW = 49;
   localparam int DIV_DW = 31;
   // Iterative square root: 64-bit radicand, 32-bit root
   localparam int SQ_RW = 64;
   localparam int SQ_QW = 32;
   // Shared multiplier
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SAT_W  = 68;

   localparam logic signed [SAT_W-1:0] SAT_HI = 68'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_LO = -68'sd2147483648;

   localparam logic [2:0] MODE_LOAD_DIR = 3'd0;
   localparam logic [2:0] MODE_NORM_DIR = 3'd1;
   localparam logic [2:0] MODE_TAUT     = 3'd2;
   localparam logic [2:0] MODE_RATE     = 3'd3;
   localparam logic [2:0] MODE_TENSION  = 3'd4;

   localparam logic [1:0] REG_CABLE_LENGTH = 2'd0;
   localparam logic [1:0] REG_TAUT_MARGIN  = 2'd1;
   localparam logic [1:0] REG_UAV_MASS     = 2'd2;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } ctu_div_req_type;

   typedef struct packed {
      logic             start;
      logic [SQ_RW-1:0] radicand;
   } ctu_sqrt_req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] val;
   } ctu_sat_type;

   // Clip to the Q16.16 range and flag the clip
   function automatic ctu_sat_type sat32(input logic signed [SAT_W-1:0] v);
      ctu_sat_type r;
      if (v > SAT_HI) begin
         r.hit = 1'b1;
         r.val = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r.hit = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.hit = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAT_W-1:0] sx_prod(input logic signed [PROD_W-1:0] v);
      return {{(SAT_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

endpackage

// ===== hw/rtl/ctu_mul.sv =====
// ----------------------------------------------------------------------------
// ctu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ctu_mul (
   input  logic                               clock,
   input  logic signed [ctu_pkg::MUL_W-1:0]   op_a,
   input  logic signed [ctu_pkg::MUL_W-1:0]   op_b,
   output logic signed [ctu_pkg::PROD_W-1:0]  prod
);
   import ctu_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/ctu_div.sv =====
// ----------------------------------------------------------------------------
// ctu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctu_div (
   input  logic                           clock,
   input  logic                           reset,
   input  ctu_pkg::ctu_div_req_type       req,
   output logic                           done,
   output logic [ctu_pkg::DIV_NW-1:0]     quotient
);
   import ctu_pkg::*;

   localparam int CNT_W = $clog2(DIV_NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_DW:0]   rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dvs_ff, dvs_in;
   logic [DIV_DW:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[DIV_DW-1:0], quo_ff[DIV_NW-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NW - 1);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/ctu_sqrt.sv =====
// ----------------------------------------------------------------------------
// ctu_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ctu_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  ctu_pkg::ctu_sqrt_req_type     req,
   output logic                          done,
   output logic [ctu_pkg::SQ_QW-1:0]     root
);
   import ctu_pkg::*;

   localparam int CNT_W = $clog2(SQ_QW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_QW+1:0] rem_ff, rem_in;
   logic [SQ_RW-1:0] rad_ff, rad_in;
   logic [SQ_QW-1:0] root_ff, root_in;
   logic [SQ_QW+1:0] rem_sh;
   logic [SQ_QW+1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[SQ_QW-1:0], rad_ff[SQ_RW-1:SQ_RW-2]};
      trial   = {root_ff, 2'b01};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SQ_QW - 1);
         rem_in  = '0;
         rad_in  = req.radicand;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_RW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SQ_QW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SQ_QW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/cable_tension_unit.sv =====
// ----------------------------------------------------------------------------
// cable_tension_unit
// One cable between a vehicle and a payload attach point, in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the req_ channel (valid/stall) and each gives exactly one
//   result item on the rsp_ channel. One item is worked on at a time; req_stall
//   is high from acceptance until the result is moved to the output register.
//   Work per item (acceptance edge to result register loaded):
//     load direction, slack tension and unused modes: straight to the output
//     taut check: decided by one component alone, or by the sum of squares
//     tension: 14 products on the shared multiplier
//     body rate: three divisions of a 49-bit quotient, then 6 products
//     normalize: stops on zero distance, otherwise a rescale by shifts,
//       three squares, the square root and three divisions
//   The bit-serial divider takes most of the time in the slow modes.
//   The output register is separate from the sequencer, so a new item is
//   taken while a result still waits on a stalled receiver; the sequencer only
//   holds at its final step when the output register is still occupied.
//   Reset clears the direction, body rate, tension and taut flag, and loads
//   the registers with length 0.5, margin 66 and mass 0.25.
//   csr_ writes land at the edge where csr_we is high; write only when idle.
// ----------------------------------------------------------------------------
module cable_tension_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vec_x,
   output logic signed [31:0] rsp_vec_y,
   output logic signed [31:0] rsp_vec_z,
   output logic signed [31:0] rsp_tension_value,
   output logic               rsp_is_taut,
   output logic               rsp_zero_length_error,
   output logic               rsp_saturated
);
   import ctu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_NSHIFT, S_NSQ, S_NSQRT, S_NDIV, S_TAUT, S_RDIV, S_CROSS, S_TENS, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       ph_ff, ph_in;

   // configuration
   logic [30:0] len_ff, len_in;
   logic [16:0] margin_ff, margin_in;
   logic [30:0] mass_ff, mass_in;

   // cable state
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] dir_in [3];
   logic signed [31:0] rate_ff [3];
   logic signed [31:0] rate_in [3];
   logic signed [31:0] ten_ff, ten_in;
   logic               taut_ff, taut_in;

   // item working registers
   logic signed [31:0] a_ff [3];
   logic signed [31:0] a_in [3];
   logic signed [31:0] b_ff [3];
   logic signed [31:0] b_in [3];
   logic [32:0]        mag_ff [3];
   logic [32:0]        mag_in [3];
   logic               neg_ff [3];
   logic               neg_in [3];
   logic signed [31:0] u_ff [3];
   logic signed [31:0] u_in [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic [63:0]        acc_ff, acc_in;
   logic [30:0]        n_ff, n_in;
   logic signed [PROD_W-1:0] hold_ff, hold_in;
   logic signed [31:0] ml_ff, ml_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [49:0] dot_ff, dot_in;
   logic               err_ff, err_in;
   logic               sat_ff, sat_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in;
   logic signed [31:0] rsp_y_ff, rsp_y_in;
   logic signed [31:0] rsp_z_ff, rsp_z_in;
   logic signed [31:0] rsp_ten_ff, rsp_ten_in;
   logic               rsp_taut_ff, rsp_taut_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // shared units
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_fl;
   ctu_div_req_type          div_req;
   logic                     div_done;
   logic [DIV_NW-1:0]        div_q;
   ctu_sqrt_req_type         sqrt_req;
   logic                     sqrt_done;
   logic [SQ_QW-1:0]         sqrt_root;

   // helpers
   logic signed [31:0] req_a [3];
   logic signed [31:0] req_b [3];
   logic [32:0]        req_mag [3];
   logic               req_neg [3];
   logic [32:0]        mx;
   logic signed [32:0] thr;
   logic               any_gt;
   logic [1:0]         lane;
   logic [1:0]         tlane;
   logic [30:0]        div_len;

   ctu_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   ctu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   ctu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign req_a[0] = req_a_x;
   assign req_a[1] = req_a_y;
   assign req_a[2] = req_a_z;
   assign req_b[0] = req_b_x;
   assign req_b[1] = req_b_y;
   assign req_b[2] = req_b_z;

   // |a - b| per lane, taken at acceptance
   always_comb begin
      logic signed [32:0] d;
      for (int i = 0; i < 3; i++) begin
         d = $signed({req_a[i][31], req_a[i]}) - $signed({req_b[i][31], req_b[i]});
         req_neg[i] = d[32];
         req_mag[i] = d[32] ? 33'(-d) : 33'(d);
      end
   end

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
   end

   assign thr     = $signed({2'b00, len_ff}) - $signed({16'b0, margin_ff});
   assign any_gt  = (mag_ff[0] > $unsigned(thr)) || (mag_ff[1] > $unsigned(thr)) ||
                    (mag_ff[2] > $unsigned(thr));
   assign lane    = step_ff[1:0];
   assign div_len = (len_ff == '0) ? 31'd1 : len_ff;
   assign prod_fl = prod >>> 16;

   // lane of the tension sequence step
   always_comb begin
      case (step_ff)
         4'd1, 4'd5, 4'd8,  4'd11: tlane = 2'd0;
         4'd2, 4'd6, 4'd9,  4'd12: tlane = 2'd1;
         4'd3, 4'd7, 4'd10, 4'd13: tlane = 2'd2;
         default:                  tlane = 2'd0;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_NSQ, S_TAUT: begin
            if (step_ff == 4'd3) begin
               mul_a = thr;
               mul_b = thr;
            end else begin
               mul_a = $signed(mag_ff[lane]);
               mul_b = $signed(mag_ff[lane]);
            end
         end
         S_CROSS: begin
            case (step_ff)
               4'd0: begin mul_a = MUL_W'(dir_ff[1]); mul_b = MUL_W'(u_ff[2]); end
               4'd1: begin mul_a = MUL_W'(dir_ff[2]); mul_b = MUL_W'(u_ff[1]); end
               4'd2: begin mul_a = MUL_W'(dir_ff[2]); mul_b = MUL_W'(u_ff[0]); end
               4'd3: begin mul_a = MUL_W'(dir_ff[0]); mul_b = MUL_W'(u_ff[2]); end
               4'd4: begin mul_a = MUL_W'(dir_ff[0]); mul_b = MUL_W'(u_ff[1]); end
               4'd5: begin mul_a = MUL_W'(dir_ff[1]); mul_b = MUL_W'(u_ff[0]); end
               default: ;
            endcase
         end
         S_TENS: begin
            case (step_ff)
               4'd0: begin
                  mul_a = $signed({2'b00, mass_ff});
                  mul_b = $signed({2'b00, len_ff});
               end
               4'd1, 4'd2, 4'd3: begin
                  mul_a = MUL_W'(rate_ff[tlane]);
                  mul_b = MUL_W'(rate_ff[tlane]);
               end
               4'd4: begin
                  mul_a = MUL_W'(ml_ff);
                  mul_b = MUL_W'(t1_ff);
               end
               4'd5, 4'd6, 4'd7: begin
                  mul_a = $signed({2'b00, mass_ff});
                  mul_b = MUL_W'(b_ff[tlane]);
               end
               4'd8, 4'd9, 4'd10: begin
                  mul_a = MUL_W'(dir_ff[tlane]);
                  mul_b = MUL_W'(u_ff[tlane]);
               end
               4'd11, 4'd12, 4'd13: begin
                  mul_a = MUL_W'(ten_ff);
                  mul_b = MUL_W'(dir_ff[tlane]);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // divider and square root launch
   always_comb begin
      div_req.start    = ((state_ff == S_NDIV) || (state_ff == S_RDIV)) && !ph_ff;
      div_req.dividend = {mag_ff[lane], 16'b0};
      div_req.divisor  = (state_ff == S_NDIV) ? n_ff : div_len;
      sqrt_req.start    = (state_ff == S_NSQ) && ph_ff && (step_ff == 4'd2);
      sqrt_req.radicand = acc_ff + prod[63:0];
   end

   // sequencer
   always_comb begin
      ctu_sat_type        r0;
      ctu_sat_type        r1;
      logic signed [49:0] sq_sv;
      logic signed [66:0] cdiff;
      logic [63:0]        sq;
      logic signed [49:0] dsum;
      logic signed [32:0] wdiff;
      logic signed [32:0] tdiff;

      state_in = state_ff;
      step_in  = step_ff;
      ph_in    = ph_ff;
      len_in    = len_ff;
      margin_in = margin_ff;
      mass_in   = mass_ff;
      dir_in  = dir_ff;
      rate_in = rate_ff;
      ten_in  = ten_ff;
      taut_in = taut_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      acc_in  = acc_ff;
      n_in    = n_ff;
      hold_in = hold_ff;
      ml_in   = ml_ff;
      t1_in   = t1_ff;
      dot_in  = dot_ff;
      err_in  = err_ff;
      sat_in  = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_ten_in   = rsp_ten_ff;
      rsp_taut_in  = rsp_taut_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_sat_in   = rsp_sat_ff;
      r0    = '0;
      r1    = '0;
      sq_sv = '0;
      cdiff = '0;
      sq    = '0;
      dsum  = '0;
      wdiff = '0;
      tdiff = '0;

      if (csr_we) begin
         case (csr_index)
            REG_CABLE_LENGTH: len_in    = csr_wdata;
            REG_TAUT_MARGIN:  margin_in = csr_wdata[16:0];
            REG_UAV_MASS:     mass_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  a_in[i]   = req_a[i];
                  b_in[i]   = req_b[i];
                  mag_in[i] = req_mag[i];
                  neg_in[i] = req_neg[i];
                  v_in[i]   = '0;
               end
               err_in  = 1'b0;
               sat_in  = 1'b0;
               acc_in  = '0;
               dot_in  = '0;
               step_in = '0;
               ph_in   = 1'b0;
               case (req_mode)
                  MODE_LOAD_DIR: begin
                     dir_in   = req_a;
                     v_in     = req_a;
                     state_in = S_FIN;
                  end
                  MODE_NORM_DIR: state_in = S_NSHIFT;
                  MODE_TAUT:     state_in = S_TAUT;
                  MODE_RATE:     state_in = S_RDIV;
                  MODE_TENSION:  state_in = taut_ff ? S_TENS : S_FIN;
                  default:       state_in = S_FIN;
               endcase
            end
         end

         S_NSHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (mx == '0) begin
               err_in   = 1'b1;
               v_in     = dir_ff;
               state_in = S_FIN;
            end else if (mx[32:30] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               state_in = S_NSQ;
            end
         end

         S_NSQ: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               acc_in = acc_ff + prod[63:0];
               ph_in  = 1'b0;
               if (step_ff == 4'd2) begin
                  step_in  = '0;
                  state_in = S_NSQRT;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_NSQRT: begin
            if (sqrt_done) begin
               n_in     = sqrt_root[30:0];
               step_in  = '0;
               ph_in    = 1'b0;
               state_in = S_NDIV;
            end
         end

         S_NDIV: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (div_done) begin
               dir_in[lane] = neg_ff[lane] ? -div_q[31:0] : div_q[31:0];
               v_in[lane]   = neg_ff[lane] ? -div_q[31:0] : div_q[31:0];
               ph_in        = 1'b0;
               if (step_ff == 4'd2) begin
                  state_in = S_FIN;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_TAUT: begin
            if (!ph_ff) begin
               if ((step_ff == 4'd0) && (thr[32] || any_gt)) begin
                  taut_in  = 1'b1;
                  state_in = S_FIN;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               if (step_ff == 4'd3) begin
                  taut_in  = acc_ff > prod[63:0];
                  state_in = S_FIN;
               end else begin
                  acc_in  = acc_ff + prod[63:0];
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_RDIV: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (div_done) begin
               // (b - a) is positive where (a - b) is negative
               sq_sv = neg_ff[lane] ? $signed({1'b0, div_q}) : -$signed({1'b0, div_q});
               r0    = sat32(SAT_W'(sq_sv));
               u_in[lane] = r0.val;
               sat_in     = sat_ff | r0.hit;
               ph_in      = 1'b0;
               if (step_ff == 4'd2) begin
                  step_in  = '0;
                  state_in = S_CROSS;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_CROSS: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (!step_ff[0]) begin
                  hold_in = prod;
               end else begin
                  cdiff = $signed({hold_ff[PROD_W-1], hold_ff}) - $signed({prod[PROD_W-1], prod});
                  r0    = sat32(SAT_W'(cdiff >>> 16));
                  rate_in[step_ff[2:1]] = r0.val;
                  v_in[step_ff[2:1]]    = r0.val;
                  sat_in                = sat_ff | r0.hit;
               end
               if (step_ff == 4'd5) begin
                  state_in = S_FIN;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_TENS: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in   = 1'b0;
               step_in = step_ff + 1'b1;
               case (step_ff)
                  4'd0: begin
                     r0     = sat32(sx_prod(prod_fl));
                     ml_in  = r0.val;
                     sat_in = sat_ff | r0.hit;
                  end
                  4'd1, 4'd2: begin
                     acc_in = acc_ff + prod[63:0];
                  end
                  4'd3: begin
                     sq     = acc_ff + prod[63:0];
                     r0     = sat32($signed({20'b0, sq[63:16]}));
                     t1_in  = r0.val;
                     sat_in = sat_ff | r0.hit;
                  end
                  4'd4: begin
                     r0     = sat32(sx_prod(prod_fl));
                     t1_in  = r0.val;
                     sat_in = sat_ff | r0.hit;
                  end
                  4'd5, 4'd6, 4'd7: begin
                     r0    = sat32(sx_prod(prod_fl));
                     wdiff = $signed({a_ff[tlane][31], a_ff[tlane]}) -
                             $signed({r0.val[31], r0.val});
                     r1    = sat32(SAT_W'(wdiff));
                     u_in[tlane] = r1.val;
                     sat_in      = sat_ff | r0.hit | r1.hit;
                  end
                  4'd8, 4'd9: begin
                     dot_in = dot_ff + prod_fl[49:0];
                  end
                  4'd10: begin
                     dsum   = dot_ff + prod_fl[49:0];
                     r0     = sat32(SAT_W'(dsum));
                     tdiff  = $signed({t1_ff[31], t1_ff}) - $signed({r0.val[31], r0.val});
                     r1     = sat32(SAT_W'(tdiff));
                     ten_in = r1.val;
                     sat_in = sat_ff | r0.hit | r1.hit;
                  end
                  4'd11, 4'd12, 4'd13: begin
                     r0          = sat32(sx_prod(prod_fl));
                     v_in[tlane] = r0.val;
                     sat_in      = sat_ff | r0.hit;
                     if (step_ff == 4'd13) state_in = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end

         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = v_ff[0];
               rsp_y_in     = v_ff[1];
               rsp_z_in     = v_ff[2];
               rsp_ten_in   = ten_ff;
               rsp_taut_in  = taut_ff;
               rsp_err_in   = err_ff;
               rsp_sat_in   = sat_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         ph_ff        <= 1'b0;
         len_ff       <= 31'd32768;
         margin_ff    <= 17'd66;
         mass_ff      <= 31'd16384;
         for (int i = 0; i < 3; i++) begin
            dir_ff[i]  <= '0;
            rate_ff[i] <= '0;
         end
         ten_ff       <= '0;
         taut_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ph_ff        <= ph_in;
         len_ff       <= len_in;
         margin_ff    <= margin_in;
         mass_ff      <= mass_in;
         dir_ff       <= dir_in;
         rate_ff      <= rate_in;
         ten_ff       <= ten_in;
         taut_ff      <= taut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      n_ff        <= n_in;
      hold_ff     <= hold_in;
      ml_ff       <= ml_in;
      t1_ff       <= t1_in;
      dot_ff      <= dot_in;
      err_ff      <= err_in;
      sat_ff      <= sat_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_ten_ff  <= rsp_ten_in;
      rsp_taut_ff <= rsp_taut_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_vec_x             = rsp_x_ff;
   assign rsp_vec_y             = rsp_y_ff;
   assign rsp_vec_z             = rsp_z_ff;
   assign rsp_tension_value     = rsp_ten_ff;
   assign rsp_is_taut           = rsp_taut_ff;
   assign rsp_zero_length_error = rsp_err_ff;
   assign rsp_saturated         = rsp_sat_ff;

   // an accepted item always occupies the sequencer in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted but sequencer did not start");

   // divider results only arrive while the sequencer waits on them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (ph_ff && ((state_ff == S_NDIV) || (state_ff == S_RDIV))))
      else $error("divider finished outside a division wait");

   // square root results only arrive in its wait state
   a_sqrt_done_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_NSQRT))
      else $error("square root finished outside its wait");

   // a zero distance never clips anything
   a_err_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_length_error) |-> !rsp_saturated)
      else $error("zero distance result flagged as saturated");

   // a new result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_vec_x == $past(rsp_vec_x)))
      else $error("waiting result overwritten");

endmodule
